### sv/assert_macros.svh
// Assertion macros shared by the page allocator modules.
// Each macro assumes a clock clk and an active-low reset rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BPA_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("page allocator assertion failed");

// Next-cycle implication, disabled while in reset.
`define BPA_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("page allocator assertion failed");

`endif

### sv/bpa_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the bitmap page allocator. No dependencies.
package bpa_pkg;

  localparam int MAP_WORDS  = 1024;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW         = $clog2(MAP_WORDS + 1);
  localparam int WIU_W      = 11;
  localparam int PG_W       = ADDR_W - PAGE_SHIFT + 1;
  localparam int PAGE_MASK  = (1 << PAGE_SHIFT) - 1;
  localparam int WIU_RESET  = 1024;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 32;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_USE = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic latch;
    logic prep;
    logic fill_init;
    logic fill_step;
    logic scan_init;
    logic scan_step;
    logic take;
    logic oom;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic range_empty;
    logic fill_last;
    logic scan_more;
    logic scan_hit;
  } dp_sts_t;

endpackage

### sv/bpa_ctrl.sv
// Sequencer for the page allocator: clearing pass, region fill and scan.
// Depends on bpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_command,
  input  logic             in_region_available,
  input  bpa_pkg::dp_sts_t sts,
  output bpa_pkg::dp_cmd_t cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_FILL,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (in_command == bpa_pkg::CMD_ALLOC) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else if (in_region_available) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.range_empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.fill_init = 1'b1;
          state_nxt     = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.take  = 1'b1;
          state_nxt = S_IDLE;
        end else if (!sts.scan_more) begin
          cmd.oom   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  // a scan always ends in exactly one result and a return to idle
  `BPA_ASSERT_NXT(a_scan_ends, cmd.take || cmd.oom, state_r == S_IDLE)

endmodule

### sv/bpa_dp.sv
// Datapath of the page allocator: config registers, bitmap memory,
// range arithmetic, fill masks and the lowest-bit finder. Depends on bpa_pkg.
`include "assert_macros.svh"

module bpa_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpa_pkg::dp_cmd_t                   cmd,
  output bpa_pkg::dp_sts_t                   sts,
  input  logic                               cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]          cfg_data,
  input  logic [bpa_pkg::ADDR_W-1:0]         in_region_start,
  input  logic [bpa_pkg::ADDR_W-1:0]         in_region_length,
  output logic                               out_strobe,
  output logic [bpa_pkg::ADDR_W-1:0]         out_page_address,
  output logic                               out_status
);

  localparam int AW     = bpa_pkg::AW;
  localparam int CW     = bpa_pkg::CW;
  localparam int PG_W   = bpa_pkg::PG_W;
  localparam int WORD_W = bpa_pkg::WORD_W;
  localparam int BIT_W  = bpa_pkg::BIT_W;
  localparam int ADDR_W = bpa_pkg::ADDR_W;

  logic [WORD_W-1:0] mem [bpa_pkg::MAP_WORDS];

  logic [ADDR_W-1:0]         lb_r;
  logic [bpa_pkg::WIU_W-1:0] wiu_r;
  logic [ADDR_W-1:0]         start_eff_r, end_r;
  logic [PG_W-1:0]           first_r, last_r, lm1_r;
  logic                      skip_r;
  logic [CW-1:0]             wc_r, wc_nxt;
  logic                      pend_v_r;
  logic [AW-1:0]             pend_addr_r;
  logic [WORD_W-1:0]         pend_mask_r;
  logic                      chk_v_r;
  logic [AW-1:0]             chk_addr_r;
  logic [WORD_W-1:0]         rdata_r;
  logic                      out_strobe_r, out_status_r;
  logic [ADDR_W-1:0]         out_addr_r;

  logic [CW-1:0]     live, fw, lw;
  logic [PG_W-1:0]   cap, end_pg, first_nxt, last_nxt;
  logic [BIT_W-1:0]  lo, hi, bidx;
  logic [WORD_W-1:0] mask, low_one, cleared;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] page_addr;

  always_comb begin
    if (32'(wiu_r) > 32'(bpa_pkg::MAP_WORDS)) live = CW'(bpa_pkg::MAP_WORDS);
    else live = CW'(wiu_r);
  end

  assign cap       = PG_W'(live) << BIT_W;
  assign end_pg    = PG_W'(end_r >> bpa_pkg::PAGE_SHIFT);
  assign first_nxt = PG_W'(({1'b0, start_eff_r} + (ADDR_W+1)'(bpa_pkg::PAGE_MASK))
                           >> bpa_pkg::PAGE_SHIFT);
  assign last_nxt  = (end_pg < cap) ? end_pg : cap;

  assign fw = CW'(first_r >> BIT_W);
  assign lw = CW'(lm1_r >> BIT_W);

  // partial masks on the first and last word of the range
  assign lo   = (wc_r == fw) ? first_r[BIT_W-1:0] : '0;
  assign hi   = (wc_r == lw) ? lm1_r[BIT_W-1:0] : '1;
  assign mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi));

  // lowest set bit: isolate, clear and encode
  assign low_one = rdata_r & (~rdata_r + WORD_W'(1));
  assign cleared = rdata_r & (rdata_r - WORD_W'(1));
  always_comb begin
    bidx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_one[i]) bidx = bidx | BIT_W'(i);
    end
  end
  assign page_addr = ADDR_W'({chk_addr_r, bidx}) << bpa_pkg::PAGE_SHIFT;

  assign sts.clear_last  = (wc_r == CW'(bpa_pkg::MAP_WORDS - 1));
  assign sts.range_empty = skip_r || (first_r >= last_r);
  assign sts.fill_last   = (wc_r == lw);
  assign sts.scan_more   = (wc_r < live);
  assign sts.scan_hit    = chk_v_r && (rdata_r != '0);

  // single write port, sources never coincide
  always_comb begin
    we    = 1'b0;
    waddr = wc_r[AW-1:0];
    wdata = '0;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (pend_v_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = rdata_r | pend_mask_r;
    end else if (cmd.take) begin
      we    = 1'b1;
      waddr = chk_addr_r;
      wdata = cleared;
    end
  end

  always_comb begin
    wc_nxt = wc_r;
    if (cmd.scan_init) wc_nxt = '0;
    else if (cmd.fill_init) wc_nxt = fw;
    else if (cmd.clear_step || cmd.fill_step || cmd.scan_step) wc_nxt = wc_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[wc_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r         <= '0;
      wiu_r        <= bpa_pkg::WIU_W'(bpa_pkg::WIU_RESET);
      wc_r         <= '0;
      pend_v_r     <= 1'b0;
      chk_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpa_pkg::REG_LOWER_BOUND:  lb_r  <= cfg_data[ADDR_W-1:0];
          bpa_pkg::REG_WORDS_IN_USE: wiu_r <= cfg_data[bpa_pkg::WIU_W-1:0];
          default: ;
        endcase
      end
      wc_r         <= wc_nxt;
      pend_v_r     <= cmd.fill_step;
      chk_v_r      <= cmd.scan_step;
      out_strobe_r <= cmd.take || cmd.oom;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      start_eff_r <= (in_region_start < lb_r) ? lb_r : in_region_start;
      end_r       <= in_region_start + in_region_length;
    end
    if (cmd.prep) begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      skip_r  <= (start_eff_r >= end_r);
    end
    if (cmd.fill_init) lm1_r <= last_r - PG_W'(1);
    if (cmd.fill_step) begin
      pend_addr_r <= wc_r[AW-1:0];
      pend_mask_r <= mask;
    end
    if (cmd.scan_step) chk_addr_r <= wc_r[AW-1:0];
    if (cmd.take) begin
      out_addr_r   <= page_addr;
      out_status_r <= bpa_pkg::ST_OK;
    end else if (cmd.oom) begin
      out_addr_r   <= '0;
      out_status_r <= bpa_pkg::ST_OOM;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_page_address = out_addr_r;
  assign out_status       = out_status_r;

  `BPA_ASSERT_IMP(a_one_writer, 1'b1, $onehot0({cmd.clear_step, pend_v_r, cmd.take}))
  `BPA_ASSERT_IMP(a_fill_in_use, cmd.fill_step, wc_r < live)

endmodule

### sv/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp and assert_macros.svh.
//
// A command is taken when start is high and busy is low. After reset the
// block runs a clearing pass over all 1024 bitmap words, one word a cycle,
// with busy high (configuration writes are still taken). An add command
// with region_available set latches the region, prepares the page range and
// checks it; unless the range holds no whole page, it then fills the range
// one bitmap word per cycle, the word read-modify-write overlapped through
// the single-port-write memory. Other add commands return to idle at once
// and give no result. An allocate command scans the words in use one per
// cycle, bounded by the memory read port, and stops at the first word that
// holds a free page, or gives out-of-memory when none does. It ends with one
// result beat on out_page_address/out_status marked by out_strobe for a
// single cycle, in the same cycle in which busy falls and a new command may
// already be taken.
// The receiver cannot stall: the beat must be taken in that cycle.
// Config writes are only legal while busy is low.
`include "assert_macros.svh"

module bitmap_page_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_region_start,
  input  logic [bpa_pkg::ADDR_W-1:0]     in_region_length,
  input  logic                           in_region_available,
  output logic                           out_strobe,
  output logic [bpa_pkg::ADDR_W-1:0]     out_page_address,
  output logic                           out_status,
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]      cfg_data
);

  bpa_pkg::dp_cmd_t cmd;
  bpa_pkg::dp_sts_t sts;

  // sequencer: only decides, never touches the bitmap
  bpa_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_command          (in_command),
    .in_region_available (in_region_available),
    .sts                 (sts),
    .cmd                 (cmd),
    .busy                (busy)
  );

  // datapath: bitmap, config and result registers
  bpa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_region_start  (in_region_start),
    .in_region_length (in_region_length),
    .out_strobe       (out_strobe),
    .out_page_address (out_page_address),
    .out_status       (out_status)
  );

  // an accepted allocate keeps the block busy until its result beat
  `BPA_ASSERT_NXT(a_alloc_busy, start && !busy && in_command == bpa_pkg::CMD_ALLOC, busy)
  // a result beat only ever follows a busy cycle
  `BPA_ASSERT_IMP(a_strobe_after_busy, out_strobe, $past(busy))

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_page_allocator: directed table, then random phases.
// Depends on bpa_pkg and the allocator RTL; predicts untyped grant beats from its bitmap.
module tb_top;
  import bpa_pkg::*;

  // Longest single operation is a full fill or a full scan: about one word a cycle.
  localparam int PAUSE_CYCLES = MAP_WORDS + 64;
  // No accepted command and no grant beat for this long means the block is stuck.
  localparam int STALL_LIMIT  = 10000;
  localparam int PHASES       = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              status;
  } grant_t;

  // Table rows: a command checked by the predictor, a command whose grant is
  // typed in below, or a register write.
  typedef enum logic [1:0] {ROW_CMD, ROW_CMD_TYPED, ROW_SET_LB, ROW_SET_WIU} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              cmd;
    logic [ADDR_W-1:0] arg_a;      // region start, or register data
    logic [ADDR_W-1:0] arg_b;      // region length
    logic              avail;
    logic [ADDR_W-1:0] want_addr;
    logic              want_status;
  } plan_row_t;

  localparam int PLAN_ROWS = 31;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // registers at their reset values
    '{ROW_SET_LB,    CMD_ADD,   32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_SET_WIU,   CMD_ADD,   32'h0000_0400, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    // empty map after reset
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OOM},
    // region not marked available: ignored
    '{ROW_CMD,       CMD_ADD,   32'h0000_0000, 32'h0000_2000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OOM},
    // one whole page, handed straight back
    '{ROW_CMD,       CMD_ADD,   32'h0000_1000, 32'h0000_1000, 1'b1, 32'h0, ST_OK},
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h1000, ST_OK},
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OOM},
    // unaligned start rounds up: pages 2 and 3
    '{ROW_CMD,       CMD_ADD,   32'h0000_1001, 32'h0000_2FFF, 1'b1, 32'h0, ST_OK},
    // end wraps past the top of the address space: skipped
    '{ROW_CMD,       CMD_ADD,   32'hFFFF_F000, 32'h0000_2000, 1'b1, 32'h0, ST_OK},
    // no whole page inside
    '{ROW_CMD,       CMD_ADD,   32'h0000_0FFF, 32'h0000_0001, 1'b1, 32'h0, ST_OK},
    // region fields ignored on allocate
    '{ROW_CMD,       CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    // bound at the very top: everything clamps away
    '{ROW_SET_LB,    CMD_ADD,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ADD,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    // bound inside the region: start raised, only page 4 whole
    '{ROW_SET_LB,    CMD_ADD,   32'h0000_3800, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ADD,   32'h0000_1000, 32'h0000_4000, 1'b1, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OOM},
    // whole address space: fills every word of the map
    '{ROW_SET_LB,    CMD_ADD,   32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ADD,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    // no word in use (upper data bits set, low eleven clear)
    '{ROW_SET_WIU,   CMD_ADD,   32'hFFFF_F800, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OOM},
    '{ROW_SET_WIU,   CMD_ADD,   32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD_TYPED, CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    // above the map size: counts as the full map
    '{ROW_SET_WIU,   CMD_ADD,   32'h0000_07FF, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_SET_WIU,   CMD_ADD,   32'h0000_0400, 32'h0000_0000, 1'b0, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    // all-ones add wraps to an end below its start
    '{ROW_CMD,       CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
    '{ROW_CMD,       CMD_ADD,   32'h0000_0000, 32'h7FFF_F000, 1'b0, 32'h0, ST_OK}
  };

  // DUT ports; every input known from time zero
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_command = CMD_ADD;
  logic [ADDR_W-1:0]    in_region_start = '0;
  logic [ADDR_W-1:0]    in_region_length = '0;
  logic                 in_region_available = 1'b0;
  logic                 out_strobe;
  logic [ADDR_W-1:0]    out_page_address;
  logic                 out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOWER_BOUND;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state: own copy of the free bitmap and both registers
  logic [WORD_W-1:0]    free_pages [MAP_WORDS];
  logic [ADDR_W-1:0]    bound_addr = '0;
  logic [WIU_W-1:0]     words_cfg  = WIU_W'(WIU_RESET);

  grant_t               grants_due [$];   // grant beats still owed, oldest first
  grant_t               owed_beat;

  int                   fail_count    = 0;
  int                   commands_sent = 0;
  int                   pages_granted = 0;
  int                   oom_replies   = 0;
  int                   reg_writes    = 0;
  int                   steady_left   = 0;
  int                   idle_cycles   = 0;

  always #10 clk = ~clk;

  bitmap_page_allocator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_region_start     (in_region_start),
    .in_region_length    (in_region_length),
    .in_region_available (in_region_available),
    .out_strobe          (out_strobe),
    .out_page_address    (out_page_address),
    .out_status          (out_status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  // Zero words in use means none; anything past the map means the whole map.
  function automatic int live_word_count();
    return (int'(words_cfg) > MAP_WORDS) ? MAP_WORDS : int'(words_cfg);
  endfunction

  // Add: raise the start to the bound, then free every whole page below the
  // wrapped end, stopping at the last word in use.
  function automatic void mark_free_range(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    logic [ADDR_W-1:0] top;
    logic [ADDR_W:0]   first_pg;
    logic [ADDR_W:0]   stop_pg;
    logic [ADDR_W:0]   cap;
    logic [ADDR_W:0]   pg;
    top = base + size;
    if (base < bound_addr) base = bound_addr;
    if (base >= top) return;
    first_pg = ({1'b0, base} + (ADDR_W+1)'(PAGE_MASK)) >> PAGE_SHIFT;
    stop_pg  = {1'b0, top} >> PAGE_SHIFT;
    cap      = (ADDR_W+1)'(live_word_count()) * (ADDR_W+1)'(WORD_W);
    if (stop_pg > cap) stop_pg = cap;
    for (pg = first_pg; pg < stop_pg; pg++)
      free_pages[int'(pg >> BIT_W)][pg[BIT_W-1:0]] = 1'b1;
  endfunction

  // Allocate: lowest set bit among the words in use, cleared on the way out.
  function automatic grant_t grant_page();
    grant_t g;
    int     words;
    g.page_address = '0;
    g.status       = ST_OOM;
    words          = live_word_count();
    for (int w = 0; w < words; w++) begin
      if (free_pages[w] != '0) begin
        for (int b = 0; b < WORD_W; b++) begin
          if (free_pages[w][b]) begin
            free_pages[w][b] = 1'b0;
            g.page_address   = ADDR_W'((w * WORD_W + b) << PAGE_SHIFT);
            g.status         = ST_OK;
            return g;
          end
        end
      end
    end
    return g;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Drive one command from the falling edge and hold it until the block takes
  // it. Start is left high on return so a zero gap keeps it high.
  task automatic issue_command(logic cmd, logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                               logic avail, logic typed, grant_t typed_beat);
    int     gap;
    grant_t predicted;
    if (steady_left != 0) begin
      steady_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 19) == 0) steady_left = $urandom_range(8, 32);
    end
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start               <= 1'b1;
    in_command          <= cmd;
    in_region_start     <= base;
    in_region_length    <= size;
    in_region_available <= avail;
    do @(posedge clk); while (busy !== 1'b0);
    commands_sent++;
    if (cmd == CMD_ALLOC) begin
      predicted = grant_page();
      grants_due.push_back(typed ? typed_beat : predicted);
    end else if (avail) begin
      mark_free_range(base, size);
    end
  endtask

  // Quiet the block: no beats owed, then long enough for a result-less fill
  // to run out, then busy low.
  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (PAUSE_CYCLES) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_LOWER_BOUND) bound_addr = data;
    else                        words_cfg  = data[WIU_W-1:0];
    reg_writes++;
  endtask

  // Mostly allocates and small adds inside the pages in use; a fifth of the
  // adds use fully random start and length to reach every bit and the wraps.
  task automatic random_command(logic [ADDR_W-1:0] span);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic              avail;
    base  = $urandom;
    size  = $urandom;
    avail = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 9) < 6) begin
      issue_command(CMD_ALLOC, base, size, avail, 1'b0, '0);
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        base = $urandom_range(0, span + 32'h4000);
        size = $urandom_range(0, 32'h6000);
        if ($urandom_range(0, 2) == 0) base[PAGE_SHIFT-1:0] = '0;
      end
      issue_command(CMD_ADD, base, size, avail, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- checking

  // Grant beats cannot be held off: check each one on the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (grants_due.size() == 0) begin
        $error("grant beat with none owed: page_address %h status %b",
               out_page_address, out_status);
        fail_count++;
      end else begin
        owed_beat = grants_due.pop_front();
        if (out_page_address !== owed_beat.page_address) begin
          $error("page_address: expected %h, got %h", owed_beat.page_address, out_page_address);
          fail_count++;
        end
        if (out_status !== owed_beat.status) begin
          $error("status: expected %b, got %b", owed_beat.status, out_status);
          fail_count++;
        end
        if (owed_beat.status == ST_OK) pages_granted++;
        else                           oom_replies++;
      end
    end
  end

  // Watchdog: any accepted command or grant beat counts as progress.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int                i;
    int                ph;
    int                n;
    int                count;
    int                wiu;
    logic              quiet;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] lb;
    grant_t            typed_beat;

    for (i = 0; i < MAP_WORDS; i++) free_pages[i] = '0;
    quiet = 1'b0;

    // synchronous reset held low from time zero, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Register rows wait for the block to go quiet first;
    // the first wait also covers the clearing pass after reset.
    for (i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_SET_LB, ROW_SET_WIU: begin
          if (!quiet) settle_block();
          quiet = 1'b1;
          write_register((PLAN[i].kind == ROW_SET_LB) ? REG_LOWER_BOUND : REG_WORDS_IN_USE,
                         PLAN[i].arg_a);
        end
        default: begin
          typed_beat.page_address = PLAN[i].want_addr;
          typed_beat.status       = PLAN[i].want_status;
          issue_command(PLAN[i].cmd, PLAN[i].arg_a, PLAN[i].arg_b, PLAN[i].avail,
                        PLAN[i].kind == ROW_CMD_TYPED, typed_beat);
          quiet = 1'b0;
        end
      endcase
    end

    // Random phases. The directed fill left the map full, so small maps
    // drain to out-of-memory within a few phases; one phase uses the full
    // map and one a middling size.
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        wiu   = MAP_WORDS;
        count = 40;
      end else if (ph == PHASES / 2) begin
        wiu   = $urandom_range(9, 64);
        count = 82;
      end else begin
        wiu   = $urandom_range(1, 4);
        count = 82;
      end
      span = ADDR_W'(wiu * WORD_W) << PAGE_SHIFT;
      case ($urandom_range(0, 5))
        0, 1:    lb = '0;
        5:       lb = $urandom;
        default: lb = $urandom_range(0, span);
      endcase
      settle_block();
      write_register(REG_LOWER_BOUND, lb);
      // junk in the bits above the register's width
      write_register(REG_WORDS_IN_USE, ($urandom & ~32'h7FF) | CFG_W'(wiu));
      for (n = 0; n < count; n++) random_command(span);
    end

    settle_block();
    $display("Run covered %0d commands: %0d pages granted, %0d out-of-memory replies.",
             commands_sent, pages_granted, oom_replies);
    $display("Register writes: %0d, command gaps of 0 to 16 cycles with unbroken runs.",
             reg_writes);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
